### rtl/bfa_pkg.sv
// ----------------------------------------------------------------------------
// bfa_pkg
// Shared constants and types for the best-fit partition allocator.
// ----------------------------------------------------------------------------
package bfa_pkg;

    localparam int NUM_BLOCKS = 16;
    localparam int SIZE_BITS  = 16;
    localparam int IDX_BITS   = 4;
    localparam int CNT_BITS   = 5;

    localparam logic [CNT_BITS-1:0] BLOCK_COUNT_RESET = CNT_BITS'(NUM_BLOCKS);

    typedef enum logic [1:0] {
        CMD_LOAD   = 2'd0,
        CMD_ALLOC  = 2'd1,
        CMD_QUERY  = 2'd2,
        CMD_UNUSED = 2'd3
    } cmd_t;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_QUERY = 5'b00010,
        ST_SCAN  = 5'b00100,
        ST_WRITE = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

endpackage

### rtl/bfa_ram.sv
// ----------------------------------------------------------------------------
// bfa_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module bfa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/best_fit_block_allocator_unit.sv
// ----------------------------------------------------------------------------
// best_fit_block_allocator_unit
// Best-fit allocator over a table of fixed memory partitions.
// ----------------------------------------------------------------------------
// Partition size and leftover live in one RAM ({size, left} per entry); taken
// marks and loaded flags are flip-flops cleared by reset, so an entry that was
// never loaded reads as size 0, leftover 0. One word is processed at a time.
// Load, bad index and unused commands go from IDLE straight to DONE; a query
// passes through QUERY; an allocate passes through SCAN over the partitions
// in use, then WRITE when it grants, and goes straight to DONE with none in
// use. The scan reads one RAM entry per cycle through the single read port,
// keeps the smallest fitting free size, then writes the leftover back. A
// result waiting in the output register does not block acceptance of the next
// input word; that word's result waits until the output register is free.
// ----------------------------------------------------------------------------
module best_fit_block_allocator_unit
    import bfa_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  cfg_wr_en,
    input  logic [CNT_BITS-1:0]   cfg_wr_data,

    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [1:0]            s_cmd,
    input  logic [IDX_BITS-1:0]   s_block_index,
    input  logic [SIZE_BITS-1:0]  s_size_value,

    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_granted,
    output logic [IDX_BITS-1:0]   m_chosen_block,
    output logic [SIZE_BITS-1:0]  m_space_left,
    output logic                  m_block_taken,
    output logic                  m_all_taken,
    output logic                  m_bad_index
);

    localparam int RAM_WIDTH = 2 * SIZE_BITS;

    state_t                 state_reg, state_next;
    logic [CNT_BITS-1:0]    block_count_reg;
    logic [NUM_BLOCKS-1:0]  taken_reg, taken_next;
    logic [NUM_BLOCKS-1:0]  loaded_reg, loaded_next;
    logic                   m_valid_reg, m_valid_next;

    logic [SIZE_BITS-1:0]   req_reg, req_next;
    logic [IDX_BITS-1:0]    idx_reg, idx_next;
    logic [IDX_BITS-1:0]    scan_reg, scan_next;
    logic [CNT_BITS-1:0]    used_reg, used_next;
    logic                   found_reg, found_next;
    logic [IDX_BITS-1:0]    best_idx_reg, best_idx_next;
    logic [SIZE_BITS-1:0]   best_size_reg, best_size_next;

    logic                   res_granted_reg, res_granted_next;
    logic [IDX_BITS-1:0]    res_chosen_reg, res_chosen_next;
    logic [SIZE_BITS-1:0]   res_left_reg, res_left_next;
    logic                   res_taken_reg, res_taken_next;
    logic                   res_bad_reg, res_bad_next;

    logic                   out_granted_reg, out_granted_next;
    logic [IDX_BITS-1:0]    out_chosen_reg, out_chosen_next;
    logic [SIZE_BITS-1:0]   out_left_reg, out_left_next;
    logic                   out_taken_reg, out_taken_next;
    logic                   out_all_reg, out_all_next;
    logic                   out_bad_reg, out_bad_next;

    logic                   ram_wr_en;
    logic [IDX_BITS-1:0]    ram_wr_addr;
    logic [RAM_WIDTH-1:0]   ram_wr_data;
    logic [IDX_BITS-1:0]    ram_rd_addr;
    logic [RAM_WIDTH-1:0]   ram_rd_data;

    logic [CNT_BITS-1:0]    used_cnt;
    logic                   accept;
    logic                   in_bad;
    logic [SIZE_BITS-1:0]   ent_size;
    logic [SIZE_BITS-1:0]   ent_left;
    logic                   ent_fit;
    logic [NUM_BLOCKS-1:0]  in_use;
    logic                   all_taken;

    bfa_ram #(
        .WIDTH (RAM_WIDTH),
        .DEPTH (NUM_BLOCKS)
    ) u_part_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign used_cnt = (block_count_reg > CNT_BITS'(NUM_BLOCKS)) ?
                      CNT_BITS'(NUM_BLOCKS) : block_count_reg;
    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign in_bad   = ({1'b0, s_block_index} >= used_cnt);

    always_comb begin
        for (int i = 0; i < NUM_BLOCKS; i++) begin
            in_use[i] = (CNT_BITS'(i) < used_cnt);
        end
    end
    assign all_taken = &(taken_reg | ~in_use);

    // RAM data of the entry being scanned or queried; unloaded entries read zero
    assign ent_size = loaded_reg[scan_reg] ? ram_rd_data[RAM_WIDTH-1:SIZE_BITS] : '0;
    assign ent_left = loaded_reg[idx_reg] ? ram_rd_data[SIZE_BITS-1:0] : '0;
    assign ent_fit  = !taken_reg[scan_reg] && (ent_size >= req_reg) &&
                      (!found_reg || (ent_size < best_size_reg));

    always_comb begin
        state_next       = state_reg;
        taken_next       = taken_reg;
        loaded_next      = loaded_reg;
        m_valid_next     = m_valid_reg;
        req_next         = req_reg;
        idx_next         = idx_reg;
        scan_next        = scan_reg;
        used_next        = used_reg;
        found_next       = found_reg;
        best_idx_next    = best_idx_reg;
        best_size_next   = best_size_reg;
        res_granted_next = res_granted_reg;
        res_chosen_next  = res_chosen_reg;
        res_left_next    = res_left_reg;
        res_taken_next   = res_taken_reg;
        res_bad_next     = res_bad_reg;
        out_granted_next = out_granted_reg;
        out_chosen_next  = out_chosen_reg;
        out_left_next    = out_left_reg;
        out_taken_next   = out_taken_reg;
        out_all_next     = out_all_reg;
        out_bad_next     = out_bad_reg;
        ram_wr_en        = 1'b0;
        ram_wr_addr      = s_block_index;
        ram_wr_data      = {s_size_value, s_size_value};
        ram_rd_addr      = scan_reg + IDX_BITS'(1);

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                ram_rd_addr = (s_cmd == CMD_QUERY) ? s_block_index : '0;
                if (accept) begin
                    req_next         = s_size_value;
                    idx_next         = s_block_index;
                    scan_next        = '0;
                    used_next        = used_cnt;
                    found_next       = 1'b0;
                    res_granted_next = 1'b0;
                    res_chosen_next  = '0;
                    res_left_next    = '0;
                    res_taken_next   = 1'b0;
                    res_bad_next     = 1'b0;
                    state_next       = ST_DONE;
                    unique case (cmd_t'(s_cmd))
                        CMD_LOAD: begin
                            res_chosen_next = s_block_index;
                            res_bad_next    = in_bad;
                            if (!in_bad) begin
                                ram_wr_en                  = 1'b1;
                                taken_next[s_block_index]  = 1'b0;
                                loaded_next[s_block_index] = 1'b1;
                                res_left_next              = s_size_value;
                            end
                        end
                        CMD_QUERY: begin
                            res_chosen_next = s_block_index;
                            res_bad_next    = in_bad;
                            if (!in_bad) begin
                                state_next = ST_QUERY;
                            end
                        end
                        CMD_ALLOC: begin
                            if (used_cnt != '0) begin
                                state_next = ST_SCAN;
                            end
                        end
                        CMD_UNUSED: begin
                        end
                    endcase
                end
            end
            ST_QUERY: begin
                res_left_next  = ent_left;
                res_taken_next = taken_reg[idx_reg];
                state_next     = ST_DONE;
            end
            ST_SCAN: begin
                if (ent_fit) begin
                    found_next     = 1'b1;
                    best_idx_next  = scan_reg;
                    best_size_next = ent_size;
                end
                scan_next = scan_reg + IDX_BITS'(1);
                if ({1'b0, scan_reg} == used_reg - CNT_BITS'(1)) begin
                    state_next = (found_reg || ent_fit) ? ST_WRITE : ST_DONE;
                end
            end
            ST_WRITE: begin
                ram_wr_en                  = 1'b1;
                ram_wr_addr                = best_idx_reg;
                ram_wr_data                = {best_size_reg, best_size_reg - req_reg};
                taken_next[best_idx_reg]   = 1'b1;
                loaded_next[best_idx_reg]  = 1'b1;
                res_granted_next           = 1'b1;
                res_chosen_next            = best_idx_reg;
                res_left_next              = best_size_reg - req_reg;
                res_taken_next             = 1'b1;
                state_next                 = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next     = 1'b1;
                    out_granted_next = res_granted_reg;
                    out_chosen_next  = res_chosen_reg;
                    out_left_next    = res_left_reg;
                    out_taken_next   = res_taken_reg;
                    out_all_next     = all_taken;
                    out_bad_next     = res_bad_reg;
                    state_next       = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            block_count_reg <= BLOCK_COUNT_RESET;
            taken_reg       <= '0;
            loaded_reg      <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg   <= state_next;
            taken_reg   <= taken_next;
            loaded_reg  <= loaded_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                block_count_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        req_reg         <= req_next;
        idx_reg         <= idx_next;
        scan_reg        <= scan_next;
        used_reg        <= used_next;
        found_reg       <= found_next;
        best_idx_reg    <= best_idx_next;
        best_size_reg   <= best_size_next;
        res_granted_reg <= res_granted_next;
        res_chosen_reg  <= res_chosen_next;
        res_left_reg    <= res_left_next;
        res_taken_reg   <= res_taken_next;
        res_bad_reg     <= res_bad_next;
        out_granted_reg <= out_granted_next;
        out_chosen_reg  <= out_chosen_next;
        out_left_reg    <= out_left_next;
        out_taken_reg   <= out_taken_next;
        out_all_reg     <= out_all_next;
        out_bad_reg     <= out_bad_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_granted      = out_granted_reg;
    assign m_chosen_block = out_chosen_reg;
    assign m_space_left   = out_left_reg;
    assign m_block_taken  = out_taken_reg;
    assign m_all_taken    = out_all_reg;
    assign m_bad_index    = out_bad_reg;

endmodule

### rtl/bfa_checker.sv
// ----------------------------------------------------------------------------
// bfa_checker
// Port-level checks for the best-fit partition allocator, bound to the top.
// ----------------------------------------------------------------------------
module bfa_checker
    import bfa_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_valid,
    input logic                 s_ready,
    input logic                 m_valid,
    input logic                 m_ready,
    input logic                 m_granted,
    input logic [IDX_BITS-1:0]  m_chosen_block,
    input logic [SIZE_BITS-1:0] m_space_left,
    input logic                 m_block_taken,
    input logic                 m_all_taken,
    input logic                 m_bad_index
);

    // stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_granted) &&
        $stable(m_chosen_block) && $stable(m_space_left) &&
        $stable(m_block_taken) && $stable(m_all_taken) && $stable(m_bad_index))
        else $error("result word changed while stalled");

    a_grant_marks: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_granted |-> m_block_taken && !m_bad_index)
        else $error("granted word without taken mark or with bad index");

    a_bad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_bad_index |-> !m_granted && !m_block_taken && m_space_left == '0)
        else $error("bad index word carries data");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while previous word still in work");

endmodule

bind best_fit_block_allocator_unit bfa_checker u_bfa_checker (.*);
